>>> rtl/asa_pkg.sv
// Package for the ADC channel scan averager.
// Shared types and constants; no dependencies.
package asa_pkg;

   // Widths fixed by the item and register formats
   localparam int unsigned SAMPLE_W  = 10;
   localparam int unsigned AVG_W     = 10;
   localparam int unsigned SUM_W     = 16;
   localparam int unsigned PTR_W     = 3;
   localparam int unsigned RIDX_W    = 4;
   localparam int unsigned ADC_SEL_W = 4;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 32;

   // Register indexes on the CSR port
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_MASK   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_MAP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CHANNEL = 2'd2;

   // Register reset values
   localparam logic [7:0]         ENABLE_MASK_RST   = 8'hFF;
   localparam logic [31:0]        CHANNEL_MAP_RST   = 32'h7654_3210;
   localparam logic [PTR_W-1:0]   START_CHANNEL_RST = 3'd5;

   // Item modes
   localparam logic MODE_SCAN = 1'b0;
   localparam logic MODE_READ = 1'b1;

   // Scan phases
   typedef enum logic [1:0] {
      PH_INIT   = 2'd0,
      PH_CONFIG = 2'd1,
      PH_SETTLE = 2'd2,
      PH_READ   = 2'd3
   } phase_type;

   // Item issued from the scan control into the update pipeline
   typedef struct packed {
      logic                  visit;      // read phase on an enabled, in-range channel
      logic [PTR_W-1:0]      chan;       // logical channel being visited
      logic [SAMPLE_W-1:0]   sample;
      logic                  rd_ok;      // read mode with an in-range index
      logic [PTR_W-1:0]      rd_chan;    // channel whose average is read
      phase_type             phase;      // phase after the item
      logic [ADC_SEL_W-1:0]  adc_select; // physical channel after the item
   } issue_type;

endpackage

>>> rtl/asa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module asa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/asa_scan_ctrl.sv
// Scan control: CSR registers, phase machine and scan pointer.
// Builds the issue record for each accepted item. Depends on asa_pkg.
module asa_scan_ctrl #(
   parameter int unsigned NUM_CHANNELS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [asa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [asa_pkg::CSR_DAT_W-1:0]      csr_write_data,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_mode,
   input  logic [asa_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic [asa_pkg::RIDX_W-1:0]         req_read_index,
   output asa_pkg::issue_type                 issue
);
   import asa_pkg::*;

   localparam logic [PTR_W:0]  NUM_P = (PTR_W + 1)'(NUM_CHANNELS);
   localparam logic [RIDX_W:0] NUM_R = (RIDX_W + 1)'(NUM_CHANNELS);

   logic [7:0]        enable_mask_ff;
   logic [31:0]       channel_map_ff;
   phase_type         phase_ff, phase_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic              accept;
   logic              scan;
   logic              in_range;
   logic [PTR_W:0]    ptr_inc;

   assign accept = req_valid & req_ready;
   assign scan   = (req_mode == MODE_SCAN);

   // CSR registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff <= ENABLE_MASK_RST;
         channel_map_ff <= CHANNEL_MAP_RST;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_ENABLE_MASK) begin
            enable_mask_ff <= csr_write_data[7:0];
         end
         if (csr_index == CSR_CHANNEL_MAP) begin
            channel_map_ff <= csr_write_data[31:0];
         end
      end
   end

   // Phase and pointer registers; a start channel write reloads the pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_INIT;
         ptr_ff   <= START_CHANNEL_RST;
      end else if (csr_write_enable && csr_index == CSR_START_CHANNEL) begin
         ptr_ff <= csr_write_data[PTR_W-1:0];
      end else if (accept && scan) begin
         phase_ff <= phase_in;
         ptr_ff   <= ptr_in;
      end
   end

   // Next phase and pointer
   assign ptr_inc = {1'b0, ptr_ff} + (PTR_W + 1)'(1);

   always_comb begin
      phase_in = phase_ff;
      ptr_in   = ptr_ff;
      unique case (phase_ff)
         PH_INIT:   phase_in = PH_CONFIG;
         PH_CONFIG: phase_in = PH_SETTLE;
         PH_SETTLE: phase_in = PH_READ;
         PH_READ: begin
            phase_in = PH_CONFIG;
            ptr_in   = (ptr_inc >= NUM_P) ? '0 : ptr_inc[PTR_W-1:0];
         end
         default:   phase_in = PH_INIT;
      endcase
   end

   // Issue record
   assign in_range = ({1'b0, ptr_ff} < NUM_P);

   always_comb begin
      issue.visit      = scan && (phase_ff == PH_READ) && in_range && enable_mask_ff[ptr_ff];
      issue.chan       = ptr_ff;
      issue.sample     = req_sample;
      issue.rd_ok      = !scan && ({1'b0, req_read_index} < NUM_R);
      issue.rd_chan    = req_read_index[PTR_W-1:0];
      issue.phase      = scan ? phase_in : phase_ff;
      issue.adc_select = scan ? channel_map_ff[{ptr_in, 2'b00} +: ADC_SEL_W]
                              : channel_map_ff[{ptr_ff, 2'b00} +: ADC_SEL_W];
   end

endmodule

>>> rtl/asa_update.sv
// Update pipeline: accumulator and average memories, read-modify-write with
// forwarding, and the result register. Depends on asa_pkg and asa_ram.
module asa_update #(
   parameter int unsigned NUM_CHANNELS = 8,
   parameter int unsigned SAMPLES      = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  asa_pkg::issue_type                issue,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_phase,
   output logic [asa_pkg::ADC_SEL_W-1:0]     rsp_adc_select,
   output logic                              rsp_sample_taken,
   output logic                              rsp_avg_updated,
   output logic [asa_pkg::PTR_W-1:0]         rsp_avg_channel,
   output logic [asa_pkg::AVG_W-1:0]         rsp_avg_value,
   output logic [asa_pkg::AVG_W-1:0]         rsp_read_value
);
   import asa_pkg::*;

   localparam int unsigned AW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int unsigned CW       = $clog2(SAMPLES + 1);
   localparam int unsigned ACC_W    = SUM_W + CW;
   // Reciprocal for exact floor(sum / SAMPLES) over the full sum range
   localparam int unsigned SAMP_LOG = $clog2(SAMPLES);
   localparam int unsigned SH       = SUM_W + SAMP_LOG;
   localparam int unsigned RW       = SUM_W + 2;
   localparam longint unsigned RECIP_L = ((64'd1 << SH) + SAMPLES - 1) / SAMPLES;
   localparam logic [RW-1:0] RECIP  = RECIP_L[RW-1:0];
   localparam logic [CW-1:0] SAMP_C = CW'(SAMPLES);

   logic                 accept, s1_move;
   logic                 s1_valid_ff;
   issue_type            s1_item_ff;
   logic                 s1_acc_vld_ff, s1_avg_vld_ff;
   logic [NUM_CHANNELS-1:0] acc_valid_ff, avg_valid_ff;
   logic [AW-1:0]        acc_rd_addr, avg_rd_addr, s1_acc_addr, s1_avg_addr;
   logic [ACC_W-1:0]     acc_rd_data, avg_unused_pad;
   logic [AVG_W-1:0]     avg_rd_data;
   // Forwarding of the most recent write to each memory
   logic                 acc_fwd_vld_ff, avg_fwd_vld_ff;
   logic [AW-1:0]        acc_fwd_addr_ff, avg_fwd_addr_ff;
   logic [ACC_W-1:0]     acc_fwd_data_ff;
   logic [AVG_W-1:0]     avg_fwd_data_ff;
   // Stage 1 datapath
   logic [ACC_W-1:0]     acc_cur;
   logic [SUM_W-1:0]     sum_cur;
   logic [CW-1:0]        cnt_cur;
   logic [SUM_W:0]       sum_add;
   logic [SUM_W+RW-1:0]  prod;
   logic [AVG_W-1:0]     quot;
   logic                 take, update;
   logic [ACC_W-1:0]     acc_wr_data;
   logic [AVG_W-1:0]     avg_read;
   // Result register
   logic                 rsp_valid_ff;
   phase_type            rsp_phase_ff;
   logic [ADC_SEL_W-1:0] rsp_adc_select_ff;
   logic                 rsp_sample_taken_ff, rsp_avg_updated_ff;
   logic [PTR_W-1:0]     rsp_avg_channel_ff;
   logic [AVG_W-1:0]     rsp_avg_value_ff, rsp_read_value_ff;

   // Handshake: stage 1 drains into the result register when it is free
   assign s1_move  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign in_ready = !s1_valid_ff || s1_move;
   assign accept   = in_valid && in_ready;

   // Read addresses stay at zero unless the item really uses the entry
   assign acc_rd_addr = issue.visit ? issue.chan[AW-1:0] : '0;
   assign avg_rd_addr = issue.rd_ok ? issue.rd_chan[AW-1:0] : '0;
   assign s1_acc_addr = s1_item_ff.chan[AW-1:0];
   assign s1_avg_addr = s1_item_ff.rd_chan[AW-1:0];

   asa_ram #(.WIDTH(ACC_W), .DEPTH(NUM_CHANNELS)) u_acc_ram (
      .clock   (clock),
      .wr_en   (s1_move && s1_item_ff.visit),
      .wr_addr (s1_acc_addr),
      .wr_data (acc_wr_data),
      .rd_en   (accept),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd_data)
   );

   asa_ram #(.WIDTH(AVG_W), .DEPTH(NUM_CHANNELS)) u_avg_ram (
      .clock   (clock),
      .wr_en   (s1_move && update),
      .wr_addr (s1_acc_addr),
      .wr_data (quot),
      .rd_en   (accept),
      .rd_addr (avg_rd_addr),
      .rd_data (avg_rd_data)
   );

   assign avg_unused_pad = '0;

   // Stage 1 register and valid-bit lookup, taken together with the memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff    <= issue;
         s1_acc_vld_ff <= acc_valid_ff[acc_rd_addr];
         s1_avg_vld_ff <= avg_valid_ff[avg_rd_addr];
      end
   end

   // Valid bits and forwarding registers; entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff   <= '0;
         avg_valid_ff   <= '0;
         acc_fwd_vld_ff <= 1'b0;
         avg_fwd_vld_ff <= 1'b0;
      end else begin
         if (s1_move && s1_item_ff.visit) begin
            acc_valid_ff[s1_acc_addr] <= 1'b1;
            acc_fwd_vld_ff            <= 1'b1;
         end
         if (s1_move && update) begin
            avg_valid_ff[s1_acc_addr] <= 1'b1;
            avg_fwd_vld_ff            <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_item_ff.visit) begin
         acc_fwd_addr_ff <= s1_acc_addr;
         acc_fwd_data_ff <= acc_wr_data;
      end
      if (s1_move && update) begin
         avg_fwd_addr_ff <= s1_acc_addr;
         avg_fwd_data_ff <= quot;
      end
   end

   // Current accumulator entry: forwarded write, stored value or zero
   always_comb begin
      if (acc_fwd_vld_ff && acc_fwd_addr_ff == s1_acc_addr) begin
         acc_cur = acc_fwd_data_ff;
      end else if (s1_acc_vld_ff) begin
         acc_cur = acc_rd_data;
      end else begin
         acc_cur = avg_unused_pad;
      end
   end

   assign sum_cur = acc_cur[ACC_W-1 -: SUM_W];
   assign cnt_cur = acc_cur[CW-1:0];

   // Accumulate while below SAMPLES, otherwise close out the average
   assign take    = s1_item_ff.visit && (cnt_cur < SAMP_C);
   assign update  = s1_item_ff.visit && !(cnt_cur < SAMP_C);
   assign sum_add = {1'b0, sum_cur} + (SUM_W + 1)'(s1_item_ff.sample);
   assign prod    = (SUM_W + RW)'(sum_cur) * (SUM_W + RW)'(RECIP);
   assign quot    = prod[SH +: AVG_W];

   assign acc_wr_data = take ? {sum_add[SUM_W-1:0], cnt_cur + CW'(1)} : '0;

   // Stored average for a read item
   always_comb begin
      if (!s1_item_ff.rd_ok) begin
         avg_read = '0;
      end else if (avg_fwd_vld_ff && avg_fwd_addr_ff == s1_avg_addr) begin
         avg_read = avg_fwd_data_ff;
      end else if (s1_avg_vld_ff) begin
         avg_read = avg_rd_data;
      end else begin
         avg_read = '0;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_phase_ff        <= s1_item_ff.phase;
         rsp_adc_select_ff   <= s1_item_ff.adc_select;
         rsp_sample_taken_ff <= take;
         rsp_avg_updated_ff  <= update;
         rsp_avg_channel_ff  <= update ? s1_item_ff.chan : '0;
         rsp_avg_value_ff    <= update ? quot : '0;
         rsp_read_value_ff   <= avg_read;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phase        = rsp_phase_ff;
   assign rsp_adc_select   = rsp_adc_select_ff;
   assign rsp_sample_taken = rsp_sample_taken_ff;
   assign rsp_avg_updated  = rsp_avg_updated_ff;
   assign rsp_avg_channel  = rsp_avg_channel_ff;
   assign rsp_avg_value    = rsp_avg_value_ff;
   assign rsp_read_value   = rsp_read_value_ff;

endmodule

>>> rtl/adc_channel_scan_averager.sv
// Top level of the ADC channel scan averager.
// Depends on asa_pkg, asa_scan_ctrl, asa_update (which uses asa_ram).

// Round-robin ADC scanner with a boxcar average per logical channel. Each
// scan item steps the phase machine (init, then configure, settle, read);
// on a read phase the enabled channel under the scan pointer accumulates the
// sample until SAMPLES are held, and its next visit stores sum / SAMPLES as
// the channel average. Read items return a stored average. Every item gives
// exactly one result. The block takes one item per clock while rsp_ready does
// not hold it back. A result is registered in stage 1 and then in the result
// register. Stalls on rsp_ready propagate back to req_ready in the same cycle.
// The rate is set by the accumulator memory's read-modify-write, which runs
// one entry per cycle unless stalled, the latest write forwarded to a read
// of the same entry. Stored state is cleared at reset through per-entry
// valid bits, so no clearing pass is needed. CSR writes must only be issued
// while the block is idle; writing start_channel also reloads the pointer.
module adc_channel_scan_averager #(
   parameter int unsigned NUM_CHANNELS = 8,
   parameter int unsigned SAMPLES      = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [asa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [asa_pkg::CSR_DAT_W-1:0]     csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [asa_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic [asa_pkg::RIDX_W-1:0]        req_read_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_phase,
   output logic [asa_pkg::ADC_SEL_W-1:0]     rsp_adc_select,
   output logic                              rsp_sample_taken,
   output logic                              rsp_avg_updated,
   output logic [asa_pkg::PTR_W-1:0]         rsp_avg_channel,
   output logic [asa_pkg::AVG_W-1:0]         rsp_avg_value,
   output logic [asa_pkg::AVG_W-1:0]         rsp_read_value
);
   import asa_pkg::*;

   issue_type issue;

   asa_scan_ctrl #(.NUM_CHANNELS(NUM_CHANNELS)) u_scan_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_sample       (req_sample),
      .req_read_index   (req_read_index),
      .issue            (issue)
   );

   asa_update #(.NUM_CHANNELS(NUM_CHANNELS), .SAMPLES(SAMPLES)) u_update (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_ready         (req_ready),
      .issue            (issue),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_phase        (rsp_phase),
      .rsp_adc_select   (rsp_adc_select),
      .rsp_sample_taken (rsp_sample_taken),
      .rsp_avg_updated  (rsp_avg_updated),
      .rsp_avg_channel  (rsp_avg_channel),
      .rsp_avg_value    (rsp_avg_value),
      .rsp_read_value   (rsp_read_value)
   );

endmodule

>>> test/adc_channel_scan_averager_tb.sv
// Self-checking testbench for adc_channel_scan_averager: scan and read traffic with
// random bursts, gaps and back-pressure, checked against a built-in scanner predictor.
// Depends on asa_pkg and the adc_channel_scan_averager RTL.
module adc_channel_scan_averager_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import asa_pkg::*;

   localparam int NUM_CHANNELS = 8;
   localparam int SAMPLES      = 16;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;

   // Unassigned slot on the register port; writes there change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // Sample value styles for the random traffic
   localparam int SAMPLE_ANY  = 0;
   localparam int SAMPLE_HIGH = 1;
   localparam int SAMPLE_LOW  = 2;

   typedef struct packed {
      logic                  mode;
      logic [SAMPLE_W-1:0]   sample;
      logic [RIDX_W-1:0]     read_index;
   } scan_item_type;

   typedef struct packed {
      phase_type             phase;
      logic [ADC_SEL_W-1:0]  adc_select;
      logic                  sample_taken;
      logic                  avg_updated;
      logic [PTR_W-1:0]      avg_channel;
      logic [AVG_W-1:0]      avg_value;
      logic [AVG_W-1:0]      read_value;
   } scan_report_type;

   // DUT connections; the inputs are all known from time zero
   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DAT_W-1:0]  csr_write_data   = '0;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic                  req_mode         = MODE_SCAN;
   logic [SAMPLE_W-1:0]   req_sample       = '0;
   logic [RIDX_W-1:0]     req_read_index   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [1:0]            rsp_phase;
   logic [ADC_SEL_W-1:0]  rsp_adc_select;
   logic                  rsp_sample_taken;
   logic                  rsp_avg_updated;
   logic [PTR_W-1:0]      rsp_avg_channel;
   logic [AVG_W-1:0]      rsp_avg_value;
   logic [AVG_W-1:0]      rsp_read_value;

   // Predictor copy of registers and scanner state
   logic [7:0]            en_mask;
   logic [31:0]           ch_map;
   logic [PTR_W-1:0]      start_ch;
   phase_type             scan_ph;
   logic [PTR_W-1:0]      scan_ptr;
   logic [SUM_W-1:0]      sum_mem [NUM_CHANNELS];
   logic [6:0]            cnt_mem [NUM_CHANNELS];
   logic [AVG_W-1:0]      avg_mem [NUM_CHANNELS];

   scan_item_type         tick_q[$];     // items waiting to be driven
   scan_report_type       report_q[$];   // predicted reports in transfer order
   scan_item_type         cur_item;

   int burst_left   = 0;
   int gap_left     = 0;
   int cycle_cnt    = 0;
   int ready_style  = 1;
   int idle_cycles  = 0;
   int error_count  = 0;
   int sent_count   = 0;
   int read_count   = 0;
   int checked      = 0;
   int taken_count  = 0;
   int stored_count = 0;
   int csr_count    = 0;

   adc_channel_scan_averager #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLES      (SAMPLES)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_sample       (req_sample),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_phase        (rsp_phase),
      .rsp_adc_select   (rsp_adc_select),
      .rsp_sample_taken (rsp_sample_taken),
      .rsp_avg_updated  (rsp_avg_updated),
      .rsp_avg_channel  (rsp_avg_channel),
      .rsp_avg_value    (rsp_avg_value),
      .rsp_read_value   (rsp_read_value)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Scanner predictor: applies one item and returns the report it should produce
   function automatic scan_report_type advance_scanner(input logic mode,
                                                       input logic [SAMPLE_W-1:0] sample,
                                                       input logic [RIDX_W-1:0] ridx);
      scan_report_type  rep;
      logic [PTR_W-1:0] ch;
      rep = '0;
      if (mode == MODE_READ) begin
         // reads leave all state alone; out-of-range index reads zero
         if (ridx < NUM_CHANNELS)
            rep.read_value = avg_mem[ridx[PTR_W-1:0]];
      end else begin
         if (scan_ph == PH_READ) begin
            ch = scan_ptr;
            if (ch < NUM_CHANNELS && en_mask[ch]) begin
               if (cnt_mem[ch] < SAMPLES) begin
                  sum_mem[ch] = sum_mem[ch] + SUM_W'(sample);
                  cnt_mem[ch] = cnt_mem[ch] + 7'd1;
                  rep.sample_taken = 1'b1;
               end else begin
                  // full window: store the average, skip this sample
                  avg_mem[ch] = AVG_W'(sum_mem[ch] / SAMPLES);
                  sum_mem[ch] = '0;
                  cnt_mem[ch] = '0;
                  rep.avg_updated = 1'b1;
                  rep.avg_channel = ch;
                  rep.avg_value   = avg_mem[ch];
               end
            end
            scan_ptr = (int'(ch) + 1 >= NUM_CHANNELS) ? '0 : ch + PTR_W'(1);
         end
         scan_ph = (scan_ph == PH_READ) ? PH_CONFIG : phase_type'(scan_ph + 1);
      end
      rep.phase      = scan_ph;
      rep.adc_select = ch_map[scan_ptr*4 +: 4];
      return rep;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_report();
      scan_report_type want;
      if (report_q.size() == 0) begin
         $display("%0t: unexpected report, expected none, actual phase %0d value %0d",
                  $time, rsp_phase, rsp_read_value);
         error_count++;
      end else begin
         want = report_q.pop_front();
         checked++;
         if (want.sample_taken) taken_count++;
         if (want.avg_updated) stored_count++;
         check_field("phase",        32'(want.phase),        32'(rsp_phase));
         check_field("adc_select",   32'(want.adc_select),   32'(rsp_adc_select));
         check_field("sample_taken", 32'(want.sample_taken), 32'(rsp_sample_taken));
         check_field("avg_updated",  32'(want.avg_updated),  32'(rsp_avg_updated));
         check_field("avg_channel",  32'(want.avg_channel),  32'(rsp_avg_channel));
         check_field("avg_value",    32'(want.avg_value),    32'(rsp_avg_value));
         check_field("read_value",   32'(want.read_value),   32'(rsp_read_value));
      end
   endtask

   // Request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            report_q.push_back(advance_scanner(req_mode, req_sample, req_read_index));
            sent_count++;
            if (req_mode == MODE_READ) read_count++;
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left != 0 || tick_q.size() == 0) begin
               if (gap_left != 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               cur_item = tick_q.pop_front();
               req_valid      <= 1'b1;
               req_mode       <= cur_item.mode;
               req_sample     <= cur_item.sample;
               req_read_index <= cur_item.read_index;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Report monitor with its own back-pressure pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_report();
         cycle_cnt++;
         if (cycle_cnt % 300 == 0)
            ready_style = $urandom_range(0, 3);
         case (ready_style)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ($urandom_range(0, 4) == 0);
            default: rsp_ready <= ((cycle_cnt % 11) < 6);
         endcase
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_item(input logic mode, input logic [SAMPLE_W-1:0] sample,
                           input logic [RIDX_W-1:0] ridx);
      scan_item_type it;
      it.mode       = mode;
      it.sample     = sample;
      it.read_index = ridx;
      tick_q.push_back(it);
   endtask

   task automatic queue_random(input int count, input int read_pct, input int style);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         case (style)
            SAMPLE_HIGH: add_item(($urandom_range(0, 99) < read_pct) ? MODE_READ : MODE_SCAN,
                                  (pick < 9) ? 10'd1023 : SAMPLE_W'($urandom_range(0, 1023)),
                                  RIDX_W'($urandom_range(0, 15)));
            SAMPLE_LOW:  add_item(($urandom_range(0, 99) < read_pct) ? MODE_READ : MODE_SCAN,
                                  (pick < 9) ? 10'd0 : SAMPLE_W'($urandom_range(0, 1023)),
                                  RIDX_W'($urandom_range(0, 15)));
            default:     add_item(($urandom_range(0, 99) < read_pct) ? MODE_READ : MODE_SCAN,
                                  (pick == 0) ? 10'd0 :
                                  (pick == 1) ? 10'd1023 : SAMPLE_W'($urandom_range(0, 1023)),
                                  RIDX_W'($urandom_range(0, 15)));
         endcase
      end
   endtask

   // Wait until every queued item is sent and every report has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (tick_q.size() != 0 || req_valid || report_q.size() != 0);
   endtask

   // One register write per clock; enable stays high across back-to-back writes
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_ENABLE_MASK:   en_mask = data[7:0];
         CSR_CHANNEL_MAP:   ch_map  = data;
         CSR_START_CHANNEL: begin
            start_ch = data[PTR_W-1:0];
            scan_ptr = start_ch;
         end
         default: ;
      endcase
      csr_count++;
   endtask

   // Reprogram all registers once the block has gone quiet
   task automatic reconfigure(input logic [7:0] mask, input logic [31:0] map,
                              input logic [PTR_W-1:0] start, input bit poke_unused);
      wait_drained();
      repeat (3) @(posedge clock);
      write_reg(CSR_ENABLE_MASK, ($urandom() & 32'hFFFF_FF00) | 32'(mask));
      write_reg(CSR_CHANNEL_MAP, map);
      write_reg(CSR_START_CHANNEL, ($urandom() & 32'hFFFF_FFF8) | 32'(start));
      if (poke_unused)
         write_reg(CSR_UNUSED, $urandom());
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Stimulus sequence
   initial begin
      en_mask  = ENABLE_MASK_RST;
      ch_map   = CHANNEL_MAP_RST;
      start_ch = START_CHANNEL_RST;
      scan_ptr = start_ch;
      scan_ph  = PH_INIT;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         sum_mem[c] = '0;
         cnt_mem[c] = '0;
         avg_mem[c] = '0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: reads of cleared averages in and out of range, then scan
      // ticks with extreme samples, which only count on the read phase
      add_item(MODE_READ, 10'd0, 4'd0);
      add_item(MODE_READ, 10'd1023, 4'd7);
      add_item(MODE_READ, 10'd0, 4'd8);
      add_item(MODE_READ, 10'd1023, 4'd15);
      for (int k = 0; k < 12; k++)
         add_item(MODE_SCAN, (k % 2) ? 10'd0 : 10'd1023, (k % 2) ? 4'd0 : 4'd15);
      add_item(MODE_READ, 10'd1023, 4'd5);
      for (int k = 0; k < 3; k++)
         add_item(MODE_SCAN, 10'd1023, 4'd5);
      add_item(MODE_READ, 10'd0, 4'd5);

      // Random traffic under the reset register values
      queue_random(350, 15, SAMPLE_ANY);

      // All channels, all mapped to physical 0, mostly full-scale samples
      reconfigure(8'hFF, 32'h0000_0000, 3'd0, 1'b0);
      queue_random(420, 5, SAMPLE_HIGH);

      // Nothing enabled: scanning must not touch any average
      reconfigure(8'h00, 32'hFFFF_FFFF, 3'd7, 1'b1);
      queue_random(80, 20, SAMPLE_ANY);

      // Random masks and maps
      reconfigure(8'($urandom_range(0, 255)), $urandom(), PTR_W'($urandom_range(0, 7)), 1'b0);
      queue_random(350, 15, SAMPLE_LOW);
      reconfigure(8'($urandom_range(0, 255)), $urandom(), PTR_W'($urandom_range(0, 7)), 1'b1);
      queue_random(300, 15, SAMPLE_ANY);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (report_q.size() != 0) begin
         $display("%0t: %0d reports never arrived, expected 0 pending, actual %0d",
                  $time, report_q.size(), report_q.size());
         error_count++;
      end

      $display("Covered %0d requests (%0d average reads) and %0d register writes;",
               sent_count, read_count, csr_count);
      $display("checked %0d reports: %0d samples accumulated, %0d averages stored, %0d errors.",
               checked, taken_count, stored_count, error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/asa_pkg.sv
rtl/asa_ram.sv
rtl/asa_scan_ctrl.sv
rtl/asa_update.sv
rtl/adc_channel_scan_averager.sv
test/adc_channel_scan_averager_tb.sv
